@@ rtl/aapr_pkg.sv @@
// -----------------------------------------------------------------------------
// aapr_pkg: shared definitions for the axis-angle point rotation pipeline
// Formats, step counts, the CORDIC arctangent table and the beat records that
// travel between the cells of the pipeline.
// -----------------------------------------------------------------------------
package aapr_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int ANGLE_BITS   = 16;
	localparam int TURN_W       = 16;

	localparam int CORDIC_STEPS = 30;
	localparam int CS_W         = 34;
	localparam int SQRT_STEPS   = 32;
	localparam int ROOT_W       = 32;
	localparam int RAD_W        = 64;
	localparam int DIV_STEPS    = 31;
	localparam int QUO_W        = 31;
	localparam int NORM_W       = 32;

	localparam logic signed [CS_W-1:0] CORDIC_START = 34'sd652032874;
	localparam logic signed [CS_W-1:0] ONE_Q30      = 34'sd1073741824;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	typedef struct packed {
		logic signed [CS_W-1:0] x;
		logic signed [CS_W-1:0] y;
		logic signed [CS_W-1:0] z;
		logic                   flip;
	} cordic_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [ROOT_W+3:0] rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic [ROOT_W-1:0] rem;
		logic [QUO_W-1:0]  num;
		logic [QUO_W-1:0]  quo;
	} div_lane_t;

endpackage

@@ rtl/aapr_delay.sv @@
// -----------------------------------------------------------------------------
// aapr_delay: payload delay line
// A row of registers that moves a word one place per advancing cycle.
// -----------------------------------------------------------------------------
module aapr_delay #(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] sr_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= din;
			for (int i = 1; i < N; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	assign dout = sr_q[N-1];

endmodule

@@ rtl/aapr_cordic_cell.sv @@
// -----------------------------------------------------------------------------
// aapr_cordic_cell: one rotation step of the sine/cosine CORDIC
// Rotates (x, y) by the arctangent of 2^-STEP toward a zero residual angle.
// -----------------------------------------------------------------------------
module aapr_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              en,
	input  aapr_pkg::cordic_t din,
	output aapr_pkg::cordic_t dout
);

	logic signed [aapr_pkg::CS_W-1:0] xs, ys, at;
	aapr_pkg::cordic_t nxt;

	always_comb begin
		xs  = din.x >>> STEP;
		ys  = din.y >>> STEP;
		at  = $signed({2'b00, aapr_pkg::ATAN_TURN[STEP]});
		nxt = din;
		if (!din.z[aapr_pkg::CS_W-1]) begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.z = din.z - at;
		end else begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.z = din.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

@@ rtl/aapr_sqrt_cell.sv @@
// -----------------------------------------------------------------------------
// aapr_sqrt_cell: one digit of the restoring integer square root
// Brings down two radicand bits and decides one root bit.
// -----------------------------------------------------------------------------
module aapr_sqrt_cell (
	input  logic            clk,
	input  logic            en,
	input  aapr_pkg::sqrt_t din,
	output aapr_pkg::sqrt_t dout
);

	localparam int RW = aapr_pkg::ROOT_W + 4;

	logic [RW-1:0] cur, trial;
	logic          ge;
	aapr_pkg::sqrt_t nxt;

	always_comb begin
		cur      = {din.rem[RW-3:0], din.rad[aapr_pkg::RAD_W-1 -: 2]};
		trial    = {2'b00, din.root, 2'b01};
		ge       = cur >= trial;
		nxt.rad  = din.rad << 2;
		nxt.rem  = ge ? (cur - trial) : cur;
		nxt.root = {din.root[aapr_pkg::ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

@@ rtl/aapr_div_cell.sv @@
// -----------------------------------------------------------------------------
// aapr_div_cell: one quotient bit of three restoring divisions
// The three axis components share one divisor, the vector length.
// -----------------------------------------------------------------------------
module aapr_div_cell (
	input  logic                            clk,
	input  logic                            en,
	input  aapr_pkg::div_lane_t [2:0]       din,
	input  logic [aapr_pkg::ROOT_W-1:0]     din_div,
	output aapr_pkg::div_lane_t [2:0]       dout,
	output logic [aapr_pkg::ROOT_W-1:0]     dout_div
);

	localparam int RW = aapr_pkg::ROOT_W;
	localparam int QW = aapr_pkg::QUO_W;

	logic [RW:0] cur [3];
	logic [RW:0] diff [3];
	logic        ge [3];
	aapr_pkg::div_lane_t [2:0] nxt;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cur[i]      = {din[i].rem, din[i].num[QW-1]};
			diff[i]     = cur[i] - {1'b0, din_div};
			ge[i]       = cur[i] >= {1'b0, din_div};
			nxt[i].rem  = ge[i] ? diff[i][RW-1:0] : cur[i][RW-1:0];
			nxt[i].num  = din[i].num << 1;
			nxt[i].quo  = {din[i].quo[QW-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout     <= nxt;
			dout_div <= din_div;
		end
	end

endmodule

@@ rtl/aapr_rmul.sv @@
// -----------------------------------------------------------------------------
// aapr_rmul: registered fixed-point product with rounding
// Gives a*b / 2^SH rounded to nearest, ties away from zero.
// -----------------------------------------------------------------------------
module aapr_rmul #(
	parameter int AW = 32,
	parameter int BW = 32,
	parameter int SH = 30,
	parameter int OW = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [OW-1:0] y
);

	localparam int PW = AW + BW;

	logic [AW-1:0]        ma;
	logic [BW-1:0]        mb;
	logic [PW-1:0]        prod;
	logic [PW:0]          rnd;
	logic [OW-1:0]        q;
	logic                 neg;

	always_comb begin
		ma   = a[AW-1] ? AW'(-a) : AW'(a);
		mb   = b[BW-1] ? BW'(-b) : BW'(b);
		prod = ma * mb;
		rnd  = {1'b0, prod} + ((PW+1)'(1) << (SH - 1));
		q    = OW'(rnd >> SH);
		neg  = a[AW-1] ^ b[BW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y <= neg ? -$signed(q) : $signed(q);
		end
	end

endmodule

@@ rtl/axis_angle_point_rotation_top.sv @@
// -----------------------------------------------------------------------------
// axis_angle_point_rotation_top: rotate a point about an axis through a pivot
// Rodrigues rotation in Q16.16 with a normalized axis, CORDIC sine/cosine and
// saturated results.
// -----------------------------------------------------------------------------
// The block takes one point per clock and returns one result per point, in
// order, through a two-entry output buffer. The pipeline depth is set by the
// chain of cells that normalize the axis: a 32-cell square root of the squared
// length followed by a 31-cell divider; the 30-cell CORDIC runs beside them.
// Every cell does one step per cycle, so a new point can enter every cycle
// while the output buffer has room. The whole pipeline holds only when the
// output buffer is full. A zero axis returns the point unchanged with the
// tuser flag set.
module axis_angle_point_rotation_top #(
	parameter int COORD_WIDTH = aapr_pkg::COORD_WIDTH,
	parameter int ANGLE_BITS  = aapr_pkg::ANGLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// point_x, point_y, point_z, pivot_x, pivot_y, pivot_z, dir_x, dir_y, dir_z,
	// turn_angle (lowest bits first)
	input  logic [((9*COORD_WIDTH+aapr_pkg::TURN_W+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// out_x, out_y, out_z (lowest bits first)
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	// axis_zero
	output logic [0:0] m_tuser
);

	localparam int CW    = COORD_WIDTH;
	localparam int PW    = CW + 1;
	localparam int XW    = CW + 5;
	localparam int OUT_W = ((3*CW+7)/8)*8;
	localparam int LW    = $clog2(CW);
	localparam int SW    = $clog2(CW + 34);
	localparam int NW    = aapr_pkg::NORM_W;
	localparam int RW    = aapr_pkg::ROOT_W;
	localparam int QW    = aapr_pkg::QUO_W;
	localparam int CSW   = aapr_pkg::CS_W;

	localparam int T_R   = 5 + aapr_pkg::SQRT_STEPS;
	localparam int T_Q   = T_R + 1 + aapr_pkg::DIV_STEPS;
	localparam int T_K   = T_Q + 1;
	localparam int T_CS  = 1 + aapr_pkg::CORDIC_STEPS + 1;
	localparam int T_OUT = T_K + 5;
	localparam int SB    = 6*CW + 3*PW + 4;

	// ---------------------------------------------------------------- control
	logic             adv;
	logic [T_OUT:1]   vld_q;
	logic [1:0]       cnt_q;
	logic             wr_q, rd_q;
	logic             push, pop;

	assign adv      = cnt_q != 2'd2;
	assign s_tready = adv;
	assign push     = adv & vld_q[T_OUT];
	assign pop      = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[T_OUT-1:1], s_tvalid};
		end
	end

	// ---------------------------------------------------------------- stage 1
	logic [2:0][CW-1:0] pt_s1, pv_s1;
	logic [2:0][PW-1:0] p_s1;
	logic [2:0][CW-1:0] a_s1;
	logic [2:0]         sgn_s1;
	logic               zero_s1;
	aapr_pkg::cordic_t  cs_s1;
	logic [CW-1:0]      din_c [3];
	logic [31:0]        ang_c, phase_c, ph_c;
	logic               flip_c;

	always_comb begin
		ang_c   = 32'(s_tdata[9*CW +: aapr_pkg::TURN_W]) & ((32'(1) << ANGLE_BITS) - 32'(1));
		phase_c = ang_c << (32 - ANGLE_BITS);
		flip_c  = phase_c[31] ^ phase_c[30];
		ph_c    = flip_c ? (phase_c ^ 32'h8000_0000) : phase_c;
		for (int i = 0; i < 3; i++) begin
			din_c[i] = s_tdata[(6+i)*CW +: CW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pt_s1[i]  <= s_tdata[i*CW +: CW];
				pv_s1[i]  <= s_tdata[(3+i)*CW +: CW];
				p_s1[i]   <= {s_tdata[i*CW+CW-1], s_tdata[i*CW +: CW]}
					- {s_tdata[(3+i)*CW+CW-1], s_tdata[(3+i)*CW +: CW]};
				a_s1[i]   <= din_c[i][CW-1] ? (~din_c[i] + CW'(1)) : din_c[i];
				sgn_s1[i] <= din_c[i][CW-1];
			end
			zero_s1    <= (din_c[0] == '0) && (din_c[1] == '0) && (din_c[2] == '0);
			cs_s1.x    <= aapr_pkg::CORDIC_START;
			cs_s1.y    <= '0;
			cs_s1.z    <= CSW'($signed(ph_c));
			cs_s1.flip <= flip_c;
		end
	end

	// ------------------------------------------- axis normalization, stages 2-5
	logic [2:0][CW-1:0] a_s2;
	logic [CW-1:0]      mx_c, mx_s2;
	logic [LW-1:0]      l_c, l_s2;
	logic [2:0][NW-1:0] an_s3;
	logic [CW+31:0]     tmp_c;
	logic [SW-1:0]      rsh_c;
	logic               ex_c;
	logic [2*NW-1:0]    sq_s4 [3];
	logic [aapr_pkg::RAD_W-1:0] rad_s5;

	always_comb begin
		mx_c = a_s1[0];
		if (a_s1[1] > mx_c) mx_c = a_s1[1];
		if (a_s1[2] > mx_c) mx_c = a_s1[2];
		l_c = '0;
		for (int j = 0; j < CW; j++) begin
			if (mx_c[j]) l_c = LW'(j);
		end
	end

	// The shift brings the largest magnitude into [2^30, 2^31]; a value that
	// truncates to exactly 2^31 stops one place early.
	always_comb begin
		tmp_c = {mx_s2, 32'b0} >> (SW'(l_s2) + SW'(1));
		ex_c  = (int'(l_s2) >= 31) && (tmp_c[31:0] == 32'h8000_0000);
		rsh_c = ex_c ? (SW'(l_s2) + SW'(1)) : (SW'(l_s2) + SW'(2));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s2 <= mx_c;
			l_s2  <= l_c;
			a_s2  <= a_s1;
			for (int i = 0; i < 3; i++) begin
				an_s3[i] <= NW'({a_s2[i], 32'b0} >> rsh_c);
				sq_s4[i] <= an_s3[i] * an_s3[i];
			end
			rad_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2];
		end
	end

	// ------------------------------------------------------ square root cells
	aapr_pkg::sqrt_t sq_ch [aapr_pkg::SQRT_STEPS+1];

	assign sq_ch[0] = '{rad: rad_s5, rem: '0, root: '0};

	for (genvar g = 0; g < aapr_pkg::SQRT_STEPS; g++) begin : g_sqrt
		aapr_sqrt_cell u_cell (
			.clk  (clk),
			.en   (adv),
			.din  (sq_ch[g]),
			.dout (sq_ch[g+1])
		);
	end

	logic [2:0][NW-1:0] an_d;

	aapr_delay #(.W(3*NW), .N(T_R - 3)) u_an_dly (
		.clk  (clk),
		.en   (adv),
		.din  (an_s3),
		.dout (an_d)
	);

	// ---------------------------------------------------------- divider cells
	aapr_pkg::div_lane_t [2:0] dv_ch [aapr_pkg::DIV_STEPS+1];
	logic [RW-1:0]             dd_ch [aapr_pkg::DIV_STEPS+1];
	logic [61:0]               num_c [3];
	logic [RW-1:0]             root_c;

	always_comb begin
		root_c = sq_ch[aapr_pkg::SQRT_STEPS].root;
		for (int i = 0; i < 3; i++) begin
			num_c[i] = (62'(an_d[i]) << 30) + 62'(root_c >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dv_ch[0][i].rem <= RW'(num_c[i][61:QW]);
				dv_ch[0][i].num <= num_c[i][QW-1:0];
				dv_ch[0][i].quo <= '0;
			end
			dd_ch[0] <= root_c;
		end
	end

	for (genvar g = 0; g < aapr_pkg::DIV_STEPS; g++) begin : g_div
		aapr_div_cell u_cell (
			.clk      (clk),
			.en       (adv),
			.din      (dv_ch[g]),
			.din_div  (dd_ch[g]),
			.dout     (dv_ch[g+1]),
			.dout_div (dd_ch[g+1])
		);
	end

	// ------------------------------------------------------------ CORDIC cells
	aapr_pkg::cordic_t cs_ch [aapr_pkg::CORDIC_STEPS+1];

	assign cs_ch[0] = cs_s1;

	for (genvar g = 0; g < aapr_pkg::CORDIC_STEPS; g++) begin : g_cordic
		aapr_cordic_cell #(.STEP(g)) u_cell (
			.clk  (clk),
			.en   (adv),
			.din  (cs_ch[g]),
			.dout (cs_ch[g+1])
		);
	end

	logic signed [CSW-1:0] cx_c, sy_c, cc_c, sc_c, t_c;
	logic [31:0]           c_s32, s_s32, omc_s32;

	always_comb begin
		cx_c = cs_ch[aapr_pkg::CORDIC_STEPS].x;
		sy_c = cs_ch[aapr_pkg::CORDIC_STEPS].y;
		if (cs_ch[aapr_pkg::CORDIC_STEPS].flip) begin
			cx_c = -cx_c;
			sy_c = -sy_c;
		end
		cc_c = (cx_c > aapr_pkg::ONE_Q30) ? aapr_pkg::ONE_Q30 :
			((cx_c < -aapr_pkg::ONE_Q30) ? -aapr_pkg::ONE_Q30 : cx_c);
		sc_c = (sy_c > aapr_pkg::ONE_Q30) ? aapr_pkg::ONE_Q30 :
			((sy_c < -aapr_pkg::ONE_Q30) ? -aapr_pkg::ONE_Q30 : sy_c);
		t_c  = aapr_pkg::ONE_Q30 - cc_c + CSW'(1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s32   <= cc_c[31:0];
			s_s32   <= sc_c[31:0];
			omc_s32 <= t_c[32:1];
		end
	end

	logic [31:0] c_s70, s_s70, omc_s70;

	aapr_delay #(.W(96), .N(T_K - T_CS)) u_cs_dly (
		.clk  (clk),
		.en   (adv),
		.din  ({omc_s32, s_s32, c_s32}),
		.dout ({omc_s70, s_s70, c_s70})
	);

	// ------------------------------------------------ side data and unit axis
	logic [SB-1:0]      side_d;
	logic [2:0][CW-1:0] pt_d, pv_d;
	logic [2:0][PW-1:0] p_d;
	logic [2:0]         sgn_d;
	logic               zero_d;

	aapr_delay #(.W(SB), .N(T_Q - 1)) u_side_dly (
		.clk  (clk),
		.en   (adv),
		.din  ({zero_s1, sgn_s1, p_s1, pv_s1, pt_s1}),
		.dout (side_d)
	);

	assign {zero_d, sgn_d, p_d, pv_d, pt_d} = side_d;

	logic [2:0][31:0]   k_s70;
	logic [2:0][PW-1:0] p_s70;
	logic [2:0][CW-1:0] pt_s70, pv_s70;
	logic               zero_s70;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				k_s70[i] <= sgn_d[i] ? -{1'b0, dv_ch[aapr_pkg::DIV_STEPS][i].quo}
					: {1'b0, dv_ch[aapr_pkg::DIV_STEPS][i].quo};
			end
			p_s70    <= p_d;
			pt_s70   <= pt_d;
			pv_s70   <= pv_d;
			zero_s70 <= zero_d;
		end
	end

	// -------------------------------------------------- Rodrigues, stages 71-75
	logic [2:0][2:0][XW-1:0] kp_s71;
	logic [2:0][XW-1:0]      pc_s71, pc_s72, pc_s73, pc_s74;
	logic [2:0][XW-1:0]      cr_s72, crs_s73, crs_s74, w_s73, wo_s74;
	logic [XW-1:0]           dot_s72;
	logic [2:0][31:0]        k_s71, k_s72;
	logic [31:0]             s_s71, s_s72, omc_s71, omc_s72, omc_s73;
	logic [2:0][CW-1:0]      pt_s71, pt_s72, pt_s73, pt_s74;
	logic [2:0][CW-1:0]      pv_s71, pv_s72, pv_s73, pv_s74, res_s75;
	logic                    zero_s71, zero_s72, zero_s73, zero_s74, zero_s75;

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			aapr_rmul #(.AW(32), .BW(PW), .SH(30), .OW(XW)) u_kp (
				.clk (clk), .en (adv), .a (k_s70[i]), .b (p_s70[j]), .y (kp_s71[i][j])
			);
		end
		aapr_rmul #(.AW(PW), .BW(32), .SH(30), .OW(XW)) u_pc (
			.clk (clk), .en (adv), .a (p_s70[i]), .b (c_s70), .y (pc_s71[i])
		);
		aapr_rmul #(.AW(32), .BW(XW), .SH(30), .OW(XW)) u_w (
			.clk (clk), .en (adv), .a (k_s72[i]), .b (dot_s72), .y (w_s73[i])
		);
		aapr_rmul #(.AW(XW), .BW(32), .SH(30), .OW(XW)) u_crs (
			.clk (clk), .en (adv), .a (cr_s72[i]), .b (s_s72), .y (crs_s73[i])
		);
		aapr_rmul #(.AW(XW), .BW(32), .SH(29), .OW(XW)) u_wo (
			.clk (clk), .en (adv), .a (w_s73[i]), .b (omc_s73), .y (wo_s74[i])
		);
	end

	logic signed [XW-1:0] sum_c [3];
	logic [CW-1:0]        sat_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = $signed(pc_s74[i]) + $signed(crs_s74[i]) + $signed(wo_s74[i])
				+ XW'($signed(pv_s74[i]));
			if (sum_c[i][XW-1:CW-1] == '0 || sum_c[i][XW-1:CW-1] == '1) begin
				sat_c[i] = sum_c[i][CW-1:0];
			end else begin
				sat_c[i] = {sum_c[i][XW-1], {(CW-1){~sum_c[i][XW-1]}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s71    <= k_s70;
			s_s71    <= s_s70;
			omc_s71  <= omc_s70;
			pt_s71   <= pt_s70;
			pv_s71   <= pv_s70;
			zero_s71 <= zero_s70;

			cr_s72[0] <= kp_s71[1][2] - kp_s71[2][1];
			cr_s72[1] <= kp_s71[2][0] - kp_s71[0][2];
			cr_s72[2] <= kp_s71[0][1] - kp_s71[1][0];
			dot_s72   <= kp_s71[0][0] + kp_s71[1][1] + kp_s71[2][2];
			pc_s72    <= pc_s71;
			k_s72     <= k_s71;
			s_s72     <= s_s71;
			omc_s72   <= omc_s71;
			pt_s72    <= pt_s71;
			pv_s72    <= pv_s71;
			zero_s72  <= zero_s71;

			pc_s73   <= pc_s72;
			omc_s73  <= omc_s72;
			pt_s73   <= pt_s72;
			pv_s73   <= pv_s72;
			zero_s73 <= zero_s72;

			pc_s74   <= pc_s73;
			crs_s74  <= crs_s73;
			pt_s74   <= pt_s73;
			pv_s74   <= pv_s73;
			zero_s74 <= zero_s73;

			for (int i = 0; i < 3; i++) begin
				res_s75[i] <= zero_s74 ? pt_s74[i] : sat_c[i];
			end
			zero_s75 <= zero_s74;
		end
	end

	// ---------------------------------------------------------- output buffer
	logic [3*CW:0] buf_q [2];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= {zero_s75, res_s75};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign m_tvalid   = cnt_q != 2'd0;
	assign m_tdata    = OUT_W'(buf_q[rd_q][3*CW-1:0]);
	assign m_tuser[0] = buf_q[rd_q][3*CW];

	// ------------------------------------------------------------- assertions
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == $past(cnt_q) + 2'($past(push)) - 2'($past(pop)))
		else $error("output buffer count lost a beat");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved while the output buffer was full");

	a_unit_axis: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[T_Q] && !zero_d |->
			dv_ch[aapr_pkg::DIV_STEPS][0].quo <= QW'(32'h4000_0000) &&
			dv_ch[aapr_pkg::DIV_STEPS][1].quo <= QW'(32'h4000_0000) &&
			dv_ch[aapr_pkg::DIV_STEPS][2].quo <= QW'(32'h4000_0000))
		else $error("unit axis component exceeds one");

endmodule
